// ===== sv/scaled_glyph_cell_renderer_defines.svh =====
// Assertion macros shared by the glyph cell renderer RTL.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef SCALED_GLYPH_CELL_RENDERER_DEFINES_SVH
`define SCALED_GLYPH_CELL_RENDERER_DEFINES_SVH

// Check cons in the cycle after ante.
`define SGCR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Check cons in the same cycle as ante.
`define SGCR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== sv/sgcr_pkg.sv =====
// Shared types, constants and the 5x7 font table of the glyph cell renderer.
// No dependencies; used by every other RTL file.
package sgcr_pkg;

	localparam int COORD_BITS_DEF = 14;
	localparam int GLYPH_ROWS     = 7;
	localparam int GLYPH_COLS     = 5;
	localparam int GLYPH_CELLS    = GLYPH_ROWS * GLYPH_COLS;
	localparam int OUT_COORD_W    = 14;
	localparam int OFF_W          = 7;

	typedef enum logic [1:0] {
		REG_ORIGIN_X   = 2'd0,
		REG_ORIGIN_Y   = 2'd1,
		REG_SCALE      = 2'd2,
		REG_TEXT_COLOR = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CM_RELOAD  = 2'd0,
		CM_CELL    = 2'd1,
		CM_ADVANCE = 2'd2
	} coord_mode_t;

	typedef struct packed {
		logic [31:0]            fill_color;
		logic [3:0]             cell_size;
		logic [OUT_COORD_W-1:0] cell_y;
		logic [OUT_COORD_W-1:0] cell_x;
		logic                   last;
	} cmd_t;

	// Return the lit cells of a character, bit row*5+col, col 0 leftmost.
	function automatic logic [GLYPH_CELLS-1:0] glyph_cells(input logic [7:0] code);
		logic [7:0]                      c;
		logic [0:GLYPH_ROWS-1][4:0]      rows;
		logic [GLYPH_CELLS-1:0]          v;
		c = code;
		if (code >= "a" && code <= "z") begin
			c = code - 8'd32;
		end
		case (c)
			"!": rows = {5'h04,5'h04,5'h04,5'h04,5'h04,5'h00,5'h04};
			"-": rows = {5'h00,5'h00,5'h00,5'h1f,5'h00,5'h00,5'h00};
			".": rows = {5'h00,5'h00,5'h00,5'h00,5'h00,5'h0c,5'h0c};
			"0": rows = {5'h0e,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0e};
			"1": rows = {5'h04,5'h0c,5'h04,5'h04,5'h04,5'h04,5'h0e};
			"2": rows = {5'h0e,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1f};
			"3": rows = {5'h1e,5'h01,5'h01,5'h0e,5'h01,5'h01,5'h1e};
			"4": rows = {5'h02,5'h06,5'h0a,5'h12,5'h1f,5'h02,5'h02};
			"5": rows = {5'h1f,5'h10,5'h10,5'h1e,5'h01,5'h01,5'h1e};
			"6": rows = {5'h0e,5'h10,5'h10,5'h1e,5'h11,5'h11,5'h0e};
			"7": rows = {5'h1f,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08};
			"8": rows = {5'h0e,5'h11,5'h11,5'h0e,5'h11,5'h11,5'h0e};
			"9": rows = {5'h0e,5'h11,5'h11,5'h0f,5'h01,5'h01,5'h0e};
			"A": rows = {5'h0e,5'h11,5'h11,5'h1f,5'h11,5'h11,5'h11};
			"B": rows = {5'h1e,5'h11,5'h11,5'h1e,5'h11,5'h11,5'h1e};
			"C": rows = {5'h0e,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0e};
			"D": rows = {5'h1e,5'h11,5'h11,5'h11,5'h11,5'h11,5'h1e};
			"E": rows = {5'h1f,5'h10,5'h10,5'h1e,5'h10,5'h10,5'h1f};
			"F": rows = {5'h1f,5'h10,5'h10,5'h1e,5'h10,5'h10,5'h10};
			"G": rows = {5'h0e,5'h11,5'h10,5'h17,5'h11,5'h11,5'h0f};
			"H": rows = {5'h11,5'h11,5'h11,5'h1f,5'h11,5'h11,5'h11};
			"I": rows = {5'h0e,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0e};
			"J": rows = {5'h07,5'h02,5'h02,5'h02,5'h12,5'h12,5'h0c};
			"K": rows = {5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11};
			"L": rows = {5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1f};
			"M": rows = {5'h11,5'h1b,5'h15,5'h15,5'h11,5'h11,5'h11};
			"N": rows = {5'h11,5'h19,5'h15,5'h13,5'h11,5'h11,5'h11};
			"O": rows = {5'h0e,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0e};
			"P": rows = {5'h1e,5'h11,5'h11,5'h1e,5'h10,5'h10,5'h10};
			"Q": rows = {5'h0e,5'h11,5'h11,5'h11,5'h15,5'h12,5'h0d};
			"R": rows = {5'h1e,5'h11,5'h11,5'h1e,5'h14,5'h12,5'h11};
			"S": rows = {5'h0f,5'h10,5'h10,5'h0e,5'h01,5'h01,5'h1e};
			"T": rows = {5'h1f,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04};
			"U": rows = {5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0e};
			"V": rows = {5'h11,5'h11,5'h11,5'h11,5'h11,5'h0a,5'h04};
			"W": rows = {5'h11,5'h11,5'h11,5'h15,5'h15,5'h15,5'h0a};
			"X": rows = {5'h11,5'h11,5'h0a,5'h04,5'h0a,5'h11,5'h11};
			"Y": rows = {5'h11,5'h11,5'h0a,5'h04,5'h04,5'h04,5'h04};
			"Z": rows = {5'h1f,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1f};
			default: rows = '0;
		endcase
		for (int r = 0; r < GLYPH_ROWS; r++) begin
			for (int k = 0; k < GLYPH_COLS; k++) begin
				v[r*GLYPH_COLS + k] = rows[r][GLYPH_COLS-1-k];
			end
		end
		return v;
	endfunction

endpackage

// ===== sv/scaled_glyph_cell_renderer.sv =====
// Scaled 5x7 glyph cell renderer: one fill command per lit font cell.
// A request loads the glyph register; lit cells go out through the output register.
// A new character is taken only in idle, after the last one is scanned and advanced.
// The scan steps one font cell a cycle through the shared coordinate adder when not stalled.
// Reset (arst_n low, asynchronous): registers to origin 0/0, scale 1, color 0, cursor 0.
// Depends on sgcr_pkg, sgcr_coord_unit, sgcr_out_stage and the defines header.
`include "scaled_glyph_cell_renderer_defines.svh"

module scaled_glyph_cell_renderer #(
	parameter int COORD_BITS = sgcr_pkg::COORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// character request in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tuser,   // [0] first
	// fill command request out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [13:0] cell_x, [27:14] cell_y, [31:28] cell_size,
	                               // [63:32] fill_color
	output logic        m_tlast    // last
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ADV
	} state_t;

	localparam logic [2:0] LAST_COL = 3'(sgcr_pkg::GLYPH_COLS - 1);

	// configuration registers
	logic signed [12:0] origin_x_q;
	logic signed [12:0] origin_y_q;
	logic [3:0]         scale_q;
	logic [31:0]        text_color_q;

	// sequencer state
	state_t                             state_q;
	logic [sgcr_pkg::GLYPH_CELLS-1:0]   glyph_q;
	logic [2:0]                         col_q;
	logic [sgcr_pkg::OFF_W-1:0]         col_off_q;
	logic [sgcr_pkg::OFF_W-1:0]         row_off_q;
	logic [3:0]                         size_q;
	logic signed [COORD_BITS-1:0]       cursor_q;

	sgcr_pkg::coord_mode_t        mode;
	logic [sgcr_pkg::OFF_W-1:0]   adv_off;
	logic signed [COORD_BITS-1:0] x_sat;
	logic signed [COORD_BITS-1:0] y_sat;
	logic                         out_ready;
	logic                         lit;
	logic                         step;
	logic                         push;
	logic                         accept;
	sgcr_pkg::cmd_t               cmd;

	// Take register writes; the host must issue them only while the block is idle (not enforced here).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q   <= '0;
			origin_y_q   <= '0;
			scale_q      <= 4'd1;
			text_color_q <= '0;
		end else if (cfg_we) begin
			unique case (sgcr_pkg::cfg_reg_t'(cfg_index))
				sgcr_pkg::REG_ORIGIN_X:   origin_x_q   <= cfg_data[12:0];
				sgcr_pkg::REG_ORIGIN_Y:   origin_y_q   <= cfg_data[12:0];
				sgcr_pkg::REG_SCALE:      scale_q      <= cfg_data[3:0];
				sgcr_pkg::REG_TEXT_COLOR: text_color_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// Current cell sits in bit 0; the glyph shifts right as the scan advances.
	assign lit  = glyph_q[0];
	assign step = (state_q == ST_SCAN) && (glyph_q != '0) && (!lit || out_ready);
	assign push = step && lit;

	// Six cells of advance: 4*s + 2*s.
	assign adv_off = sgcr_pkg::OFF_W'({size_q, 2'b00}) + sgcr_pkg::OFF_W'({size_q, 1'b0});

	always_comb begin
		unique case (state_q)
			ST_IDLE: mode = sgcr_pkg::CM_RELOAD;
			ST_SCAN: mode = sgcr_pkg::CM_CELL;
			ST_ADV:  mode = sgcr_pkg::CM_ADVANCE;
			default: mode = sgcr_pkg::CM_CELL;
		endcase
	end

	sgcr_coord_unit #(
		.COORD_BITS(COORD_BITS)
	) u_coord (
		.mode     (mode),
		.origin_x (origin_x_q),
		.origin_y (origin_y_q),
		.cursor   (cursor_q),
		.col_off  (col_off_q),
		.row_off  (row_off_q),
		.adv_off  (adv_off),
		.x_sat    (x_sat),
		.y_sat    (y_sat)
	);

	// Mark last when no lit cell remains beyond the current one.
	always_comb begin
		cmd.cell_x     = sgcr_pkg::OUT_COORD_W'(x_sat);
		cmd.cell_y     = sgcr_pkg::OUT_COORD_W'(y_sat);
		cmd.cell_size  = size_q;
		cmd.fill_color = text_color_q;
		cmd.last       = (glyph_q[sgcr_pkg::GLYPH_CELLS-1:1] == '0);
	end

	sgcr_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.cmd      (cmd),
		.ready    (out_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// Sequencer: take a character, scan its cells, advance the cursor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			glyph_q   <= '0;
			col_q     <= '0;
			col_off_q <= '0;
			row_off_q <= '0;
			size_q    <= 4'd1;
			cursor_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						glyph_q   <= sgcr_pkg::glyph_cells(s_tdata);
						col_q     <= '0;
						col_off_q <= '0;
						row_off_q <= '0;
						size_q    <= (scale_q == 4'd0) ? 4'd1 : scale_q;
						// Reload the cursor from the saturated origin.
						if (s_tuser) begin
							cursor_q <= x_sat;
						end
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (glyph_q == '0) begin
						state_q <= ST_ADV;
					end else if (step) begin
						glyph_q <= glyph_q >> 1;
						if (col_q == LAST_COL) begin
							col_q     <= '0;
							col_off_q <= '0;
							row_off_q <= row_off_q + sgcr_pkg::OFF_W'(size_q);
						end else begin
							col_q     <= col_q + 3'd1;
							col_off_q <= col_off_q + sgcr_pkg::OFF_W'(size_q);
						end
					end
				end
				ST_ADV: begin
					cursor_q <= x_sat;
					state_q  <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`SGCR_ASSERT_NEXT(a_accept_scans, accept, state_q == ST_SCAN, "no scan after a request")
	`SGCR_ASSERT_NEXT(a_last_empties, push && cmd.last, glyph_q == '0, "cells left after last")
	`SGCR_ASSERT_NEXT(a_scan_shifts, step, glyph_q == ($past(glyph_q) >> 1), "scan lost a cell")
	`SGCR_ASSERT_SAME(a_size_nonzero, m_tvalid, m_tdata[31:28] != 4'd0, "zero fill size")

endmodule

// ===== sv/sgcr_coord_unit.sv =====
// Shared saturating coordinate adder of the glyph cell renderer.
// Depends on sgcr_pkg for the mode codes and offset width.
module sgcr_coord_unit #(
	parameter int COORD_BITS = sgcr_pkg::COORD_BITS_DEF
) (
	input  sgcr_pkg::coord_mode_t             mode,
	input  logic signed [12:0]                origin_x,
	input  logic signed [12:0]                origin_y,
	input  logic signed [COORD_BITS-1:0]      cursor,
	input  logic [sgcr_pkg::OFF_W-1:0]        col_off,
	input  logic [sgcr_pkg::OFF_W-1:0]        row_off,
	input  logic [sgcr_pkg::OFF_W-1:0]        adv_off,
	output logic signed [COORD_BITS-1:0]      x_sat,
	output logic signed [COORD_BITS-1:0]      y_sat
);

	logic signed [COORD_BITS:0]   x_base;
	logic [sgcr_pkg::OFF_W-1:0]   x_off;
	logic signed [COORD_BITS+1:0] x_sum;
	logic signed [COORD_BITS+1:0] y_sum;

	function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [COORD_BITS+1:0] v);
		logic [2:0] top;
		top = v[COORD_BITS+1:COORD_BITS-1];
		if (top == 3'b000 || top == 3'b111) begin
			return v[COORD_BITS-1:0];
		end else if (v[COORD_BITS+1]) begin
			return {1'b1, {(COORD_BITS-1){1'b0}}};
		end else begin
			return {1'b0, {(COORD_BITS-1){1'b1}}};
		end
	endfunction

	always_comb begin
		unique case (mode)
			sgcr_pkg::CM_RELOAD: begin
				x_base = (COORD_BITS+1)'(origin_x);
				x_off  = '0;
			end
			sgcr_pkg::CM_CELL: begin
				x_base = (COORD_BITS+1)'(cursor);
				x_off  = col_off;
			end
			sgcr_pkg::CM_ADVANCE: begin
				x_base = (COORD_BITS+1)'(cursor);
				x_off  = adv_off;
			end
			default: begin
				x_base = (COORD_BITS+1)'(cursor);
				x_off  = '0;
			end
		endcase
	end

	assign x_sum = (COORD_BITS+2)'(x_base) + (COORD_BITS+2)'($signed({1'b0, x_off}));
	assign y_sum = (COORD_BITS+2)'(origin_y) + (COORD_BITS+2)'($signed({1'b0, row_off}));
	assign x_sat = sat(x_sum);
	assign y_sat = sat(y_sum);

endmodule

// ===== sv/sgcr_out_stage.sv =====
// Output register of the glyph cell renderer: holds one fill command request.
// Depends on sgcr_pkg for the command struct.
module sgcr_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  sgcr_pkg::cmd_t     cmd,
	output logic               ready,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [63:0]        m_tdata,
	output logic               m_tlast
);

	logic           valid_q;
	sgcr_pkg::cmd_t cmd_q;

	assign ready = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && push) begin
			cmd_q <= cmd;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {cmd_q.fill_color, cmd_q.cell_size, cmd_q.cell_y, cmd_q.cell_x};
	assign m_tlast  = cmd_q.last;

endmodule

// ===== test/tb_scaled_glyph_cell_renderer.sv =====
// Self-checking testbench for scaled_glyph_cell_renderer: a table of directed
// requests, then random text lines under several idle mixes and a long output hold-off.
// Depends on sgcr_pkg and the renderer RTL only.
module tb_scaled_glyph_cell_renderer;
	timeunit 1ns;
	timeprecision 1ps;
	import sgcr_pkg::*;

	localparam int COORD_MAX     = (1 << (COORD_BITS_DEF - 1)) - 1;
	localparam int COORD_MIN     = -COORD_MAX - 1;
	localparam int ADVANCE_CELLS = 6;
	localparam int SETTLE_CYCLES = 48;   // a full 35-cell scan plus pipeline, with margin
	localparam int HOLD_CYCLES   = 400;  // long output hold-off for the pressure phase
	localparam int UNTYPED       = -1;   // table row checked by the predictor alone
	localparam logic [8*39-1:0] GLYPH_SET = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789!-.";

	// One row of the directed table: either a register write or a character.
	typedef struct packed {
		bit          is_wr;
		cfg_reg_t    addr;
		logic [31:0] data;
		logic [7:0]  code;
		bit          first;
		int          want_n;   // typed number of fills, or UNTYPED
		int          want_x;   // typed origin of the first fill
		int          want_y;
	} plan_step_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic        m_tlast;

	// Mirror of the block's registers and running cursor.
	logic signed [12:0] cfg_org_x;
	logic signed [12:0] cfg_org_y;
	logic [3:0]         cfg_scale;
	logic [31:0]        cfg_color;
	int                 pen_x;

	cmd_t       pending_fills[$];
	cmd_t       want_fill;
	plan_step_t plan[$];
	int         err_cnt = 0;
	int         tx_idle_pct = 0;
	int         rx_stall_pct = 0;
	bit         hold_go = 1'b0;
	int         hold_left = 0;

	scaled_glyph_cell_renderer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Lit cells of a character as seven 5-bit rows, row 0 in the top bits and
	// column 0 at bit 4 of each row. Fold lowercase; anything without a glyph is blank.
	function automatic logic [34:0] font_rows(input logic [7:0] code);
		logic [7:0] u;
		u = (code >= "a" && code <= "z") ? code - 8'd32 : code;
		case (u)
			"!": return {5'h04,5'h04,5'h04,5'h04,5'h04,5'h00,5'h04};
			"-": return {5'h00,5'h00,5'h00,5'h1f,5'h00,5'h00,5'h00};
			".": return {5'h00,5'h00,5'h00,5'h00,5'h00,5'h0c,5'h0c};
			"0": return {5'h0e,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0e};
			"1": return {5'h04,5'h0c,5'h04,5'h04,5'h04,5'h04,5'h0e};
			"2": return {5'h0e,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1f};
			"3": return {5'h1e,5'h01,5'h01,5'h0e,5'h01,5'h01,5'h1e};
			"4": return {5'h02,5'h06,5'h0a,5'h12,5'h1f,5'h02,5'h02};
			"5": return {5'h1f,5'h10,5'h10,5'h1e,5'h01,5'h01,5'h1e};
			"6": return {5'h0e,5'h10,5'h10,5'h1e,5'h11,5'h11,5'h0e};
			"7": return {5'h1f,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08};
			"8": return {5'h0e,5'h11,5'h11,5'h0e,5'h11,5'h11,5'h0e};
			"9": return {5'h0e,5'h11,5'h11,5'h0f,5'h01,5'h01,5'h0e};
			"A": return {5'h0e,5'h11,5'h11,5'h1f,5'h11,5'h11,5'h11};
			"B": return {5'h1e,5'h11,5'h11,5'h1e,5'h11,5'h11,5'h1e};
			"C": return {5'h0e,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0e};
			"D": return {5'h1e,5'h11,5'h11,5'h11,5'h11,5'h11,5'h1e};
			"E": return {5'h1f,5'h10,5'h10,5'h1e,5'h10,5'h10,5'h1f};
			"F": return {5'h1f,5'h10,5'h10,5'h1e,5'h10,5'h10,5'h10};
			"G": return {5'h0e,5'h11,5'h10,5'h17,5'h11,5'h11,5'h0f};
			"H": return {5'h11,5'h11,5'h11,5'h1f,5'h11,5'h11,5'h11};
			"I": return {5'h0e,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0e};
			"J": return {5'h07,5'h02,5'h02,5'h02,5'h12,5'h12,5'h0c};
			"K": return {5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11};
			"L": return {5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1f};
			"M": return {5'h11,5'h1b,5'h15,5'h15,5'h11,5'h11,5'h11};
			"N": return {5'h11,5'h19,5'h15,5'h13,5'h11,5'h11,5'h11};
			"O": return {5'h0e,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0e};
			"P": return {5'h1e,5'h11,5'h11,5'h1e,5'h10,5'h10,5'h10};
			"Q": return {5'h0e,5'h11,5'h11,5'h11,5'h15,5'h12,5'h0d};
			"R": return {5'h1e,5'h11,5'h11,5'h1e,5'h14,5'h12,5'h11};
			"S": return {5'h0f,5'h10,5'h10,5'h0e,5'h01,5'h01,5'h1e};
			"T": return {5'h1f,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04};
			"U": return {5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0e};
			"V": return {5'h11,5'h11,5'h11,5'h11,5'h11,5'h0a,5'h04};
			"W": return {5'h11,5'h11,5'h11,5'h15,5'h15,5'h15,5'h0a};
			"X": return {5'h11,5'h11,5'h0a,5'h04,5'h0a,5'h11,5'h11};
			"Y": return {5'h11,5'h11,5'h0a,5'h04,5'h04,5'h04,5'h04};
			"Z": return {5'h1f,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1f};
			default: return '0;
		endcase
	endfunction

	function automatic int clamp_coord(input int v);
		if (v > COORD_MAX) return COORD_MAX;
		if (v < COORD_MIN) return COORD_MIN;
		return v;
	endfunction

	// Queue the fill commands one character produces and advance the cursor.
	// Return the number of fills and hand back the first one.
	function automatic int predict_glyph(input logic [7:0] code, input bit first,
	                                     output cmd_t head);
		logic [34:0] lit;
		int          s;
		int          n;
		int          k;
		cmd_t        c;
		lit  = font_rows(code);
		s    = (cfg_scale == 4'd0) ? 1 : int'(cfg_scale);   // zero scale acts as one
		n    = $countones(lit);
		k    = 0;
		head = '0;
		if (first) begin
			pen_x = clamp_coord(int'(cfg_org_x));
		end
		for (int r = 0; r < GLYPH_ROWS; r++) begin
			for (int col = 0; col < GLYPH_COLS; col++) begin
				if (lit[34 - r*GLYPH_COLS - col]) begin
					k++;
					c.cell_x     = 14'(clamp_coord(pen_x + col*s));
					c.cell_y     = 14'(clamp_coord(int'(cfg_org_y) + r*s));
					c.cell_size  = 4'(s);
					c.fill_color = cfg_color;
					c.last       = (k == n);
					if (k == 1) begin
						head = c;
					end
					pending_fills.push_back(c);
				end
			end
		end
		// blank glyphs give nothing but still move the cursor
		pen_x = clamp_coord(pen_x + ADVANCE_CELLS*s);
		return n;
	endfunction

	function automatic plan_step_t wr_step(input cfg_reg_t addr, input logic [31:0] data);
		plan_step_t st;
		st        = '0;
		st.is_wr  = 1'b1;
		st.addr   = addr;
		st.data   = data;
		st.want_n = UNTYPED;
		return st;
	endfunction

	function automatic plan_step_t glyph_step(input logic [7:0] code, input bit first,
	                                          input int want_n, input int want_x,
	                                          input int want_y);
		plan_step_t st;
		st        = '0;
		st.addr   = REG_ORIGIN_X;
		st.code   = code;
		st.first  = first;
		st.want_n = want_n;
		st.want_x = want_x;
		st.want_y = want_y;
		return st;
	endfunction

	// Write one register through the port and keep the mirror in step.
	// Only call with the block idle.
	task automatic set_reg(input cfg_reg_t idx, input logic [31:0] d);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ORIGIN_X:   cfg_org_x = d[12:0];
			REG_ORIGIN_Y:   cfg_org_y = d[12:0];
			REG_SCALE:      cfg_scale = d[3:0];
			REG_TEXT_COLOR: cfg_color = d;
			default: ;
		endcase
	endtask

	// Offer one character request, with a random idle gap first, and predict
	// its fills at the edge where it is taken.
	task automatic offer_glyph(input logic [7:0] code, input bit first,
	                           output int n, output cmd_t head);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= code;
		s_tuser  <= first;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		n = predict_glyph(code, first, head);
	endtask

	// Drop valid, wait for every expected fill, then let a trailing scan of
	// blank characters finish before anything touches the registers.
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_fills.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Output side: stall at the current rate, or hold off completely for a
	// counted stretch when the pressure phase asks for it.
	always @(negedge clk) begin
		if (hold_go) begin
			hold_go   = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Compare every accepted fill command against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_fills.size() == 0) begin
				$display("%0t: unexpected fill request data=%h last=%b",
				         $time, m_tdata, m_tlast);
				err_cnt++;
			end else begin
				want_fill = pending_fills.pop_front();
				if (m_tdata[13:0] !== want_fill.cell_x) begin
					$display("%0t: cell_x expected %h actual %h",
					         $time, want_fill.cell_x, m_tdata[13:0]);
					err_cnt++;
				end
				if (m_tdata[27:14] !== want_fill.cell_y) begin
					$display("%0t: cell_y expected %h actual %h",
					         $time, want_fill.cell_y, m_tdata[27:14]);
					err_cnt++;
				end
				if (m_tdata[31:28] !== want_fill.cell_size) begin
					$display("%0t: cell_size expected %h actual %h",
					         $time, want_fill.cell_size, m_tdata[31:28]);
					err_cnt++;
				end
				if (m_tdata[63:32] !== want_fill.fill_color) begin
					$display("%0t: fill_color expected %h actual %h",
					         $time, want_fill.fill_color, m_tdata[63:32]);
					err_cnt++;
				end
				if (m_tlast !== want_fill.last) begin
					$display("%0t: last expected %b actual %b",
					         $time, want_fill.last, m_tlast);
					err_cnt++;
				end
			end
		end
	end

	initial begin : stimulus
		plan_step_t  st;
		int          n;
		int          line_len;
		int          pick;
		cmd_t        head;
		logic [7:0]  code;
		bit          first;
		logic [31:0] junk;
		logic [12:0] ox;
		logic [12:0] oy;
		logic [3:0]  sc;
		logic [31:0] color;

		cfg_org_x = '0;
		cfg_org_y = '0;
		cfg_scale = 4'd1;
		cfg_color = '0;
		pen_x     = 0;

		// Directed table. After reset: origin 0/0, scale 1, color 0.
		plan.push_back(glyph_step(" ", 1'b1, 0, 0, 0));        // blank, cursor still moves
		plan.push_back(glyph_step("-", 1'b0, 5, 6, 3));        // cursor now at 6
		plan.push_back(glyph_step(".", 1'b1, 4, 1, 5));        // reload to origin
		plan.push_back(glyph_step(8'hFF, 1'b0, 0, 0, 0));      // code without glyph
		plan.push_back(glyph_step(8'h00, 1'b0, 0, 0, 0));
		plan.push_back(glyph_step("a", 1'b0, UNTYPED, 0, 0));  // lowercase fold
		plan.push_back(glyph_step("z", 1'b0, UNTYPED, 0, 0));
		plan.push_back(glyph_step("Z", 1'b0, UNTYPED, 0, 0));
		plan.push_back(wr_step(REG_SCALE, 32'hFFFF_FFF0));     // zero scale acts as one
		plan.push_back(glyph_step("!", 1'b1, 6, 2, 0));
		plan.push_back(wr_step(REG_TEXT_COLOR, 32'hFFFF_FFFF));
		plan.push_back(wr_step(REG_ORIGIN_X, 32'h0000_0FFF));  // most positive origin
		plan.push_back(wr_step(REG_ORIGIN_Y, 32'hFFFF_F000));  // most negative origin
		plan.push_back(wr_step(REG_SCALE, 32'h0000_000F));
		plan.push_back(glyph_step("-", 1'b1, 5, 4095, -4051));
		plan.push_back(glyph_step("8", 1'b0, UNTYPED, 0, 0));
		plan.push_back(glyph_step("W", 1'b0, UNTYPED, 0, 0));
		plan.push_back(wr_step(REG_ORIGIN_X, 32'h0000_1000));
		plan.push_back(wr_step(REG_ORIGIN_Y, 32'hABCD_EFFF));
		plan.push_back(wr_step(REG_TEXT_COLOR, 32'h0000_0000));
		plan.push_back(glyph_step(".", 1'b1, 4, -4081, 4170));
		plan.push_back(glyph_step("m", 1'b0, UNTYPED, 0, 0));
		plan.push_back(glyph_step("Q", 1'b0, UNTYPED, 0, 0));
		plan.push_back(wr_step(REG_SCALE, 32'h0000_0001));
		plan.push_back(glyph_step("0", 1'b1, UNTYPED, 0, 0));

		// Hold reset, then release it on a falling edge.
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		tx_idle_pct  = 26;
		rx_stall_pct = 26;
		foreach (plan[i]) begin
			st = plan[i];
			if (st.is_wr) begin
				settle();
				set_reg(st.addr, st.data);
			end else begin
				offer_glyph(st.code, st.first, n, head);
				if (st.want_n != UNTYPED &&
				    (n != st.want_n || (n > 0 &&
				     (int'($signed(head.cell_x)) != st.want_x ||
				      int'($signed(head.cell_y)) != st.want_y)))) begin
					$display("%0t: row %0d expected %0d fills from (%0d,%0d), actual %0d from (%0d,%0d)",
					         $time, i, st.want_n, st.want_x, st.want_y, n,
					         $signed(head.cell_x), $signed(head.cell_y));
					err_cnt++;
				end
			end
		end

		// Random phases: fresh settings each time, text in lines that start with
		// a cursor reload. Phase 0 is one long line at the right edge and full
		// scale so the cursor runs into saturation; phase 5 holds the output off.
		for (int ph = 0; ph < 8; ph++) begin
			settle();
			case (ph % 4)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 67; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 67; end
				default: begin tx_idle_pct = 26; rx_stall_pct = 26; end
			endcase
			ox    = 13'($urandom);
			oy    = 13'($urandom);
			sc    = 4'($urandom_range(0, 15));
			color = $urandom;
			case (ph)
				0: begin ox = 13'h0FFF; sc = 4'd15; end
				1: begin ox = 13'h1000; oy = 13'h0FFF; sc = 4'd1; color = '0; end
				2: begin sc = 4'd0; color = 32'hFFFF_FFFF; end
				5: begin tx_idle_pct = 0; rx_stall_pct = 0; end
				default: ;
			endcase
			// junk in the unused upper bits must be ignored
			junk = $urandom;
			set_reg(REG_ORIGIN_X, {junk[31:13], ox});
			junk = $urandom;
			set_reg(REG_ORIGIN_Y, {junk[31:13], oy});
			junk = $urandom;
			set_reg(REG_SCALE, {junk[31:4], sc});
			set_reg(REG_TEXT_COLOR, color);
			if (ph == 5) begin
				hold_go = 1'b1;
			end
			line_len = (ph == 0) ? 60 : 24;
			for (int i = 0; i < line_len; i++) begin
				pick = $urandom_range(99);
				if (pick < 60) begin
					code = GLYPH_SET[8*$urandom_range(0, 38) +: 8];
				end else if (pick < 75) begin
					code = 8'("a" + $urandom_range(0, 25));
				end else if (pick < 85) begin
					code = " ";
				end else begin
					code = 8'($urandom_range(0, 255));
				end
				first = (i == 0) || (ph != 0 && $urandom_range(99) < 12);
				offer_glyph(code, first, n, head);
			end
		end

		settle();
		if (err_cnt == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Run limit, far beyond the slowest correct run.
	initial begin
		#10_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+sv
sv/sgcr_pkg.sv
sv/sgcr_coord_unit.sv
sv/sgcr_out_stage.sv
sv/scaled_glyph_cell_renderer.sv
test/tb_scaled_glyph_cell_renderer.sv
